// ----- rtl/core/rptn_pkg.sv -----
package rptn_pkg;

   typedef enum logic [1:0] {
      MODE_DOWN = 2'd0,
      MODE_PRE  = 2'd1,
      MODE_UP   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_BLOCK    = 3'd1,
      CMD_RELEASE  = 3'd2,
      CMD_FLUSH    = 3'd3,
      CMD_LINKUP   = 3'd4,
      CMD_LINKDOWN = 3'd5,
      CMD_FORWARD  = 3'd6
   } cmd_type;

   localparam logic [1:0] ACT_LINK  = 2'd0;
   localparam logic [1:0] ACT_FRAME = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_DOMAIN         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RING_ID        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRIMARY_PORT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SECONDARY_PORT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONTROL_VLAN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HELLO_CODE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COMMON_FLUSH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COMPLETE_FLUSH = 3'd7;

   localparam logic [39:0] MAC_PREFIX = 40'h01_80_C2_00_00;
   localparam logic [7:0]  CODE_LOW   = 8'h11;
   localparam logic [7:0]  CODE_HIGH  = 8'h1F;
   localparam logic [15:0] TPID_VLAN  = 16'h8100;

   // at most three actions per event
   localparam int NUM_SLOTS = 3;
   localparam int SLOT_W    = 2;

   typedef struct packed {
      logic [15:0] ring_domain;
      logic [15:0] ring_id;
      logic [5:0]  primary_port;
      logic [5:0]  secondary_port;
      logic [11:0] control_vlan;
      logic [7:0]  hello_code;
      logic [7:0]  common_flush_code;
      logic [7:0]  complete_flush_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        primary_link;
      logic        secondary_link;
      logic [47:0] dest_mac;
      logic        tag_present;
      logic [5:0]  source_port_index;
      logic [15:0] tag_protocol_id;
      logic [11:0] frame_vlan;
      logic [15:0] frame_domain;
      logic [15:0] frame_ring;
   } req_type;

   // one event's worth of results
   typedef struct packed {
      logic [NUM_SLOTS-1:0][2:0] cmd;
      logic [NUM_SLOTS-1:0][5:0] port;
      logic [SLOT_W-1:0]         count;
      logic [1:0]                mode;
   } rec_type;

endpackage

// ----- rtl/core/rptn_cfg.sv -----
module rptn_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [rptn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rptn_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rptn_pkg::cfg_type               cfg
);

   rptn_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rptn_pkg::REG_DOMAIN:         cfg_in.ring_domain         = csr_wdata;
            rptn_pkg::REG_RING_ID:        cfg_in.ring_id             = csr_wdata;
            rptn_pkg::REG_PRIMARY_PORT:   cfg_in.primary_port        = csr_wdata[5:0];
            rptn_pkg::REG_SECONDARY_PORT: cfg_in.secondary_port      = csr_wdata[5:0];
            rptn_pkg::REG_CONTROL_VLAN:   cfg_in.control_vlan        = csr_wdata[11:0];
            rptn_pkg::REG_HELLO_CODE:     cfg_in.hello_code          = csr_wdata[7:0];
            rptn_pkg::REG_COMMON_FLUSH:   cfg_in.common_flush_code   = csr_wdata[7:0];
            rptn_pkg::REG_COMPLETE_FLUSH: cfg_in.complete_flush_code = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_domain         <= 16'd0;
         cfg_ff.ring_id             <= 16'd0;
         cfg_ff.primary_port        <= 6'd1;
         cfg_ff.secondary_port      <= 6'd2;
         cfg_ff.control_vlan        <= 12'd1;
         cfg_ff.hello_code          <= 8'd21;
         cfg_ff.common_flush_code   <= 8'd23;
         cfg_ff.complete_flush_code <= 8'd24;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/rptn_front.sv -----
module rptn_front #(
   parameter int TIMEOUT_TICKS = 30
) (
   input  logic              clock,
   input  logic              reset,
   input  rptn_pkg::cfg_type cfg,
   input  logic              req_valid,
   input  rptn_pkg::req_type req,
   input  logic              queue_full,
   output logic              push,
   output rptn_pkg::rec_type rec
);

   localparam int CntW = $clog2(TIMEOUT_TICKS + 1);
   localparam logic [CntW-1:0] TimeoutLim = CntW'(TIMEOUT_TICKS);

   rptn_pkg::mode_type mode_ff, mode_in;
   logic               init_ff, init_in;
   logic               plink_ff, plink_in;
   logic               slink_ff, slink_in;
   logic [5:0]         blocked_ff, blocked_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;

   logic [6:0] ingress_port;
   logic       src_primary;
   logic       frame_ok;
   logic [7:0] code;
   logic [5:0] fwd_port;

   assign push = req_valid && !queue_full;

   assign code         = req.dest_mac[7:0];
   assign ingress_port = {1'b0, req.source_port_index} + 7'd1;
   assign src_primary  = (ingress_port == {1'b0, cfg.primary_port});
   // primary wins when both ring ports are configured equal
   assign fwd_port     = src_primary ? cfg.secondary_port : cfg.primary_port;

   assign frame_ok = (req.dest_mac[47:8] == rptn_pkg::MAC_PREFIX)
                  && (code >= rptn_pkg::CODE_LOW) && (code <= rptn_pkg::CODE_HIGH)
                  && req.tag_present
                  && (src_primary || (ingress_port == {1'b0, cfg.secondary_port}))
                  && (req.tag_protocol_id == rptn_pkg::TPID_VLAN)
                  && (req.frame_vlan == cfg.control_vlan)
                  && (req.frame_domain == cfg.ring_domain)
                  && (req.frame_ring == cfg.ring_id);

   always_comb begin
      mode_in    = mode_ff;
      init_in    = init_ff;
      plink_in   = plink_ff;
      slink_in   = slink_ff;
      blocked_in = blocked_ff;
      cnt_in     = cnt_ff;
      rec.cmd    = '0;
      rec.port   = '0;
      rec.count  = rptn_pkg::SLOT_W'(1);

      case (req.action)
         rptn_pkg::ACT_LINK: begin
            if (!init_ff) begin
               init_in = 1'b1;
               mode_in = (req.primary_link && req.secondary_link) ?
                         rptn_pkg::MODE_UP : rptn_pkg::MODE_DOWN;
            end else begin
               if (req.primary_link != plink_ff) begin
                  if (mode_in == rptn_pkg::MODE_DOWN && req.primary_link) begin
                     if (req.secondary_link) begin
                        mode_in     = rptn_pkg::MODE_PRE;
                        blocked_in  = cfg.primary_port;
                        rec.cmd[0]  = rptn_pkg::CMD_BLOCK;
                        rec.port[0] = cfg.primary_port;
                        rec.cmd[1]  = rptn_pkg::CMD_LINKUP;
                        rec.port[1] = cfg.secondary_port;
                        rec.count   = rptn_pkg::SLOT_W'(2);
                     end
                  end else if (mode_in == rptn_pkg::MODE_UP && !req.primary_link) begin
                     mode_in     = rptn_pkg::MODE_DOWN;
                     rec.cmd[0]  = rptn_pkg::CMD_LINKDOWN;
                     rec.port[0] = cfg.secondary_port;
                  end
               end
               // the secondary can only act when the primary step emitted nothing
               if (req.secondary_link != slink_ff) begin
                  if (mode_in == rptn_pkg::MODE_DOWN && req.secondary_link) begin
                     if (req.primary_link) begin
                        mode_in     = rptn_pkg::MODE_PRE;
                        blocked_in  = cfg.secondary_port;
                        rec.cmd[0]  = rptn_pkg::CMD_BLOCK;
                        rec.port[0] = cfg.secondary_port;
                        rec.cmd[1]  = rptn_pkg::CMD_LINKUP;
                        rec.port[1] = cfg.primary_port;
                        rec.count   = rptn_pkg::SLOT_W'(2);
                     end
                  end else if (mode_in == rptn_pkg::MODE_UP && !req.secondary_link) begin
                     mode_in     = rptn_pkg::MODE_DOWN;
                     rec.cmd[0]  = rptn_pkg::CMD_LINKDOWN;
                     rec.port[0] = cfg.primary_port;
                  end
               end
            end
            plink_in = req.primary_link;
            slink_in = req.secondary_link;
         end
         rptn_pkg::ACT_FRAME: begin
            if (frame_ok) begin
               if (code == cfg.hello_code) begin
                  rec.cmd[0]  = rptn_pkg::CMD_FORWARD;
                  rec.port[0] = fwd_port;
               end else if (code == cfg.common_flush_code) begin
                  rec.cmd[0] = rptn_pkg::CMD_FLUSH;
               end else if (code == cfg.complete_flush_code) begin
                  rec.cmd[0]  = rptn_pkg::CMD_FORWARD;
                  rec.port[0] = fwd_port;
                  cnt_in      = '0;
                  if (mode_ff == rptn_pkg::MODE_PRE) begin
                     mode_in     = rptn_pkg::MODE_UP;
                     rec.cmd[1]  = rptn_pkg::CMD_RELEASE;
                     rec.port[1] = blocked_ff;
                     rec.cmd[2]  = rptn_pkg::CMD_FLUSH;
                     rec.count   = rptn_pkg::SLOT_W'(3);
                  end
               end
            end
         end
         rptn_pkg::ACT_TICK: begin
            if (mode_ff == rptn_pkg::MODE_PRE) begin
               if (cnt_ff >= TimeoutLim) begin
                  cnt_in      = '0;
                  mode_in     = rptn_pkg::MODE_UP;
                  rec.cmd[0]  = rptn_pkg::CMD_RELEASE;
                  rec.port[0] = blocked_ff;
                  rec.cmd[1]  = rptn_pkg::CMD_FLUSH;
                  rec.count   = rptn_pkg::SLOT_W'(2);
               end else begin
                  cnt_in = cnt_ff + CntW'(1);
               end
            end else begin
               cnt_in = '0;
            end
         end
         default: ;
      endcase

      rec.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= rptn_pkg::MODE_DOWN;
         init_ff    <= 1'b0;
         plink_ff   <= 1'b0;
         slink_ff   <= 1'b0;
         blocked_ff <= 6'd0;
         cnt_ff     <= '0;
      end else if (push) begin
         mode_ff    <= mode_in;
         init_ff    <= init_in;
         plink_ff   <= plink_in;
         slink_ff   <= slink_in;
         blocked_ff <= blocked_in;
         cnt_ff     <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/rptn_queue.sv -----
module rptn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rptn_pkg::rec_type wr_rec,
   output logic              full,
   input  logic              pop,
   output rptn_pkg::rec_type rd_rec,
   output logic              empty
);

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   rptn_pkg::rec_type slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == CntW'(Depth));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_rec  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/rptn_back.sv -----
module rptn_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  rptn_pkg::rec_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_command,
   output logic [5:0]        rsp_target_port,
   output logic [1:0]        rsp_node_state,
   output logic              rsp_last
);

   logic                        valid_ff;
   rptn_pkg::rec_type           rec_ff;
   logic [rptn_pkg::SLOT_W-1:0] idx_ff;
   logic                        last;
   logic                        taken;
   logic                        load;

   assign last  = (idx_ff == rec_ff.count - rptn_pkg::SLOT_W'(1));
   assign taken = valid_ff && !rsp_stall;
   // pull the next event when none is held, or once the final item of the current one is taken
   assign load  = !valid_ff || (taken && last);
   assign pop   = load && !queue_empty;

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= !queue_empty;
         idx_ff   <= '0;
      end else if (taken) begin
         idx_ff <= idx_ff + rptn_pkg::SLOT_W'(1);
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_command     = rec_ff.cmd[idx_ff];
   assign rsp_target_port = rec_ff.port[idx_ff];
   assign rsp_node_state  = rec_ff.mode;
   assign rsp_last        = last;

endmodule

// ----- rtl/core/ring_protection_transit_node.sv -----
// Ring protection transit node.
// req_ channel: one event per item (link sample, parsed frame header or
// 100 ms tick). The item is taken at a clock edge with req_valid high and
// req_stall low. The node state is updated in the cycle the item is taken.
// rsp_ channel: each event yields one to three items (command, target port,
// node state after the event), the final one flagged by rsp_last. An event
// with no action yields a single item with command none.
// csr_ channel: csr_ready is always high; index 0..7 selects domain, ring,
// primary port, secondary port, control VLAN, hello, common flush and
// complete flush codes. Write only while no event is in flight.
// The event is written to the event queue, then loaded into the output
// register, which raises rsp_valid for its first result. Rates: one event
// per cycle at the input while the queue is not full, one result per cycle
// at the output while rsp_stall is low; a two-entry event queue decouples
// the two sides.
// rsp_stall holds the current result; the queue keeps taking events until
// it is full, then req_stall rises.
// Reset (synchronous): node down, links treated as not yet sampled,
// registers back to their defaults, queue and output emptied.
module ring_protection_transit_node #(
   parameter int TIMEOUT_TICKS = 30
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic                            req_primary_link,
   input  logic                            req_secondary_link,
   input  logic [47:0]                     req_dest_mac,
   input  logic                            req_tag_present,
   input  logic [5:0]                      req_source_port_index,
   input  logic [15:0]                     req_tag_protocol_id,
   input  logic [11:0]                     req_frame_vlan,
   input  logic [15:0]                     req_frame_domain,
   input  logic [15:0]                     req_frame_ring,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_command,
   output logic [5:0]                      rsp_target_port,
   output logic [1:0]                      rsp_node_state,
   output logic                            rsp_last,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rptn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rptn_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rptn_pkg::cfg_type cfg;
   rptn_pkg::req_type req;
   rptn_pkg::rec_type wr_rec;
   rptn_pkg::rec_type head;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;

   assign req.action            = req_action;
   assign req.primary_link      = req_primary_link;
   assign req.secondary_link    = req_secondary_link;
   assign req.dest_mac          = req_dest_mac;
   assign req.tag_present       = req_tag_present;
   assign req.source_port_index = req_source_port_index;
   assign req.tag_protocol_id   = req_tag_protocol_id;
   assign req.frame_vlan        = req_frame_vlan;
   assign req.frame_domain      = req_frame_domain;
   assign req.frame_ring        = req_frame_ring;

   rptn_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rptn_front #(
      .TIMEOUT_TICKS (TIMEOUT_TICKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .rec        (wr_rec)
   );

   rptn_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_rec (wr_rec),
      .full   (queue_full),
      .pop    (pop),
      .rd_rec (head),
      .empty  (queue_empty)
   );

   rptn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .rsp_target_port (rsp_target_port),
      .rsp_node_state  (rsp_node_state),
      .rsp_last        (rsp_last)
   );

   // a quiet event is always a single item
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == rptn_pkg::CMD_NONE |-> rsp_last)
      else $error("command none not marked last");

   a_portless_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_command == rptn_pkg::CMD_NONE || rsp_command == rptn_pkg::CMD_FLUSH)
      |-> rsp_target_port == 6'd0)
      else $error("flush or none with nonzero port");

   a_block_pre: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == rptn_pkg::CMD_BLOCK |-> rsp_node_state == rptn_pkg::MODE_PRE)
      else $error("block issued outside preforwarding");

   a_release_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == rptn_pkg::CMD_RELEASE
      |-> rsp_node_state == rptn_pkg::MODE_UP && !rsp_last)
      else $error("release must lead to up and be followed by flush");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int TICK_LIMIT = 30;
   localparam int CYCLE_LIMIT = 300000;
   localparam int ITEMS_PER_PHASE = 60;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      rptn_pkg::cmd_type  cmd;
      logic [5:0]         port;
      rptn_pkg::mode_type state;
      logic               last;
   } exp_type;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   rptn_pkg::req_type req_cur = '0;
   logic [1:0]        req_action;
   logic              req_primary_link;
   logic              req_secondary_link;
   logic [47:0]       req_dest_mac;
   logic              req_tag_present;
   logic [5:0]        req_source_port_index;
   logic [15:0]       req_tag_protocol_id;
   logic [11:0]       req_frame_vlan;
   logic [15:0]       req_frame_domain;
   logic [15:0]       req_frame_ring;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_command;
   logic [5:0]  rsp_target_port;
   logic [1:0]  rsp_node_state;
   logic        rsp_last;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [rptn_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rptn_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   assign req_action            = req_cur.action;
   assign req_primary_link      = req_cur.primary_link;
   assign req_secondary_link    = req_cur.secondary_link;
   assign req_dest_mac          = req_cur.dest_mac;
   assign req_tag_present       = req_cur.tag_present;
   assign req_source_port_index = req_cur.source_port_index;
   assign req_tag_protocol_id   = req_cur.tag_protocol_id;
   assign req_frame_vlan        = req_cur.frame_vlan;
   assign req_frame_domain      = req_cur.frame_domain;
   assign req_frame_ring        = req_cur.frame_ring;

   ring_protection_transit_node #(
      .TIMEOUT_TICKS(TICK_LIMIT)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_primary_link      (req_primary_link),
      .req_secondary_link    (req_secondary_link),
      .req_dest_mac          (req_dest_mac),
      .req_tag_present       (req_tag_present),
      .req_source_port_index (req_source_port_index),
      .req_tag_protocol_id   (req_tag_protocol_id),
      .req_frame_vlan        (req_frame_vlan),
      .req_frame_domain      (req_frame_domain),
      .req_frame_ring        (req_frame_ring),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_command           (rsp_command),
      .rsp_target_port       (rsp_target_port),
      .rsp_node_state        (rsp_node_state),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // node model: state, register copy and the actions it predicts
   // ---------------------------------------------------------------
   rptn_pkg::cfg_type  cfg_model;
   rptn_pkg::mode_type node_mode;
   bit                 link_seen;
   logic               prim_prev;
   logic               sec_prev;
   logic [5:0]         blocked_port;
   logic [4:0]         tick_count;
   rptn_pkg::cmd_type  act_cmd[$];
   logic [5:0]         act_port[$];
   exp_type            action_q[$];

   rptn_pkg::req_type event_q[$];
   int      queued = 0;
   int      err_count = 0;
   int      cycle_count = 0;
   bit      idle_on = 1'b0;
   bit      req_fire = 1'b0;
   int      gap_left = 0;
   int      stall_left = 0;

   function automatic void emit_action(input rptn_pkg::cmd_type c, input logic [5:0] p);
      act_cmd.push_back(c);
      act_port.push_back(p);
   endfunction

   function automatic void link_edge(input logic [5:0] port, input logic level,
                                     input logic [5:0] other, input logic other_level);
      if (node_mode == rptn_pkg::MODE_DOWN && level) begin
         if (other_level) begin
            node_mode = rptn_pkg::MODE_PRE;
            blocked_port = port;
            emit_action(rptn_pkg::CMD_BLOCK, port);
            emit_action(rptn_pkg::CMD_LINKUP, other);
         end
      end else if (node_mode == rptn_pkg::MODE_UP && !level) begin
         node_mode = rptn_pkg::MODE_DOWN;
         emit_action(rptn_pkg::CMD_LINKDOWN, other);
      end
   endfunction

   // primary match wins when both ring ports are the same number
   function automatic void forward_from(input logic [6:0] src);
      if (src == {1'b0, cfg_model.primary_port})
         emit_action(rptn_pkg::CMD_FORWARD, cfg_model.secondary_port);
      else if (src == {1'b0, cfg_model.secondary_port})
         emit_action(rptn_pkg::CMD_FORWARD, cfg_model.primary_port);
   endfunction

   function automatic void release_ring();
      tick_count = '0;
      node_mode = rptn_pkg::MODE_UP;
      emit_action(rptn_pkg::CMD_RELEASE, blocked_port);
      emit_action(rptn_pkg::CMD_FLUSH, 6'd0);
   endfunction

   task automatic advance_node(input rptn_pkg::req_type ev);
      logic [6:0] src;
      logic [7:0] code;
      exp_type    a;
      act_cmd.delete();
      act_port.delete();
      src = {1'b0, ev.source_port_index} + 7'd1;
      code = ev.dest_mac[7:0];
      case (ev.action)
         rptn_pkg::ACT_LINK: begin
            if (!link_seen) begin
               link_seen = 1'b1;
               node_mode = (ev.primary_link && ev.secondary_link) ?
                           rptn_pkg::MODE_UP : rptn_pkg::MODE_DOWN;
            end else begin
               if (ev.primary_link != prim_prev)
                  link_edge(cfg_model.primary_port, ev.primary_link,
                            cfg_model.secondary_port, ev.secondary_link);
               if (ev.secondary_link != sec_prev)
                  link_edge(cfg_model.secondary_port, ev.secondary_link,
                            cfg_model.primary_port, ev.primary_link);
            end
            prim_prev = ev.primary_link;
            sec_prev = ev.secondary_link;
         end
         rptn_pkg::ACT_FRAME: begin
            if (ev.dest_mac[47:8] == rptn_pkg::MAC_PREFIX
                && code >= rptn_pkg::CODE_LOW && code <= rptn_pkg::CODE_HIGH
                && ev.tag_present
                && (src == {1'b0, cfg_model.primary_port}
                    || src == {1'b0, cfg_model.secondary_port})
                && ev.tag_protocol_id == rptn_pkg::TPID_VLAN
                && ev.frame_vlan == cfg_model.control_vlan
                && ev.frame_domain == cfg_model.ring_domain
                && ev.frame_ring == cfg_model.ring_id) begin
               if (code == cfg_model.hello_code) begin
                  forward_from(src);
               end else if (code == cfg_model.common_flush_code) begin
                  emit_action(rptn_pkg::CMD_FLUSH, 6'd0);
               end else if (code == cfg_model.complete_flush_code) begin
                  forward_from(src);
                  tick_count = '0;
                  if (node_mode == rptn_pkg::MODE_PRE)
                     release_ring();
               end
            end
         end
         rptn_pkg::ACT_TICK: begin
            if (node_mode == rptn_pkg::MODE_PRE) begin
               if (tick_count >= TICK_LIMIT)
                  release_ring();
               else
                  tick_count = tick_count + 5'd1;
            end else begin
               tick_count = '0;
            end
         end
         default: ;
      endcase
      if (act_cmd.size() == 0)
         emit_action(rptn_pkg::CMD_NONE, 6'd0);
      foreach (act_cmd[k]) begin
         a.cmd = act_cmd[k];
         a.port = act_port[k];
         a.state = node_mode;
         a.last = (k == act_cmd.size() - 1);
         action_q.push_back(a);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_model.ring_domain = 16'd0;
         cfg_model.ring_id = 16'd0;
         cfg_model.primary_port = 6'd1;
         cfg_model.secondary_port = 6'd2;
         cfg_model.control_vlan = 12'd1;
         cfg_model.hello_code = 8'd21;
         cfg_model.common_flush_code = 8'd23;
         cfg_model.complete_flush_code = 8'd24;
         node_mode = rptn_pkg::MODE_DOWN;
         link_seen = 1'b0;
         prim_prev = 1'b0;
         sec_prev = 1'b0;
         blocked_port = '0;
         tick_count = '0;
         req_fire <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rptn_pkg::REG_DOMAIN:         cfg_model.ring_domain = csr_wdata;
               rptn_pkg::REG_RING_ID:        cfg_model.ring_id = csr_wdata;
               rptn_pkg::REG_PRIMARY_PORT:   cfg_model.primary_port = csr_wdata[5:0];
               rptn_pkg::REG_SECONDARY_PORT: cfg_model.secondary_port = csr_wdata[5:0];
               rptn_pkg::REG_CONTROL_VLAN:   cfg_model.control_vlan = csr_wdata[11:0];
               rptn_pkg::REG_HELLO_CODE:     cfg_model.hello_code = csr_wdata[7:0];
               rptn_pkg::REG_COMMON_FLUSH:   cfg_model.common_flush_code = csr_wdata[7:0];
               rptn_pkg::REG_COMPLETE_FLUSH: cfg_model.complete_flush_code = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            advance_node(req_cur);
         req_fire <= req_valid && !req_stall;
      end
   end

   // ---------------------------------------------------------------
   // event driver and result stall, both change on the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (event_q.size() != 0) begin
            req_cur <= event_q.pop_front();
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && !reset && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_results
      exp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (action_q.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected item: cmd=%0d port=%0d state=%0d last=%0d",
                        rsp_command, rsp_target_port, rsp_node_state, rsp_last);
         end else begin
            want = action_q.pop_front();
            if (rsp_command !== want.cmd || rsp_target_port !== want.port
                || rsp_node_state !== want.state || rsp_last !== want.last) begin
               err_count++;
               if (err_count <= 10)
                  $display("mismatch: cmd=%0d/%0d port=%0d/%0d state=%0d/%0d last=%0d/%0d %s",
                           rsp_command, want.cmd, rsp_target_port, want.port,
                           rsp_node_state, want.state, rsp_last, want.last,
                           "(actual/expected)");
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   function automatic rptn_pkg::req_type rand_fields();
      rptn_pkg::req_type f;
      logic [63:0]       rnd;
      rnd = {$urandom, $urandom};
      f.action = 2'($urandom_range(0, 3));
      f.primary_link = 1'($urandom_range(0, 1));
      f.secondary_link = 1'($urandom_range(0, 1));
      f.dest_mac = rnd[47:0];
      f.tag_present = 1'($urandom_range(0, 1));
      f.source_port_index = 6'($urandom_range(0, 63));
      f.tag_protocol_id = 16'($urandom_range(0, 65535));
      f.frame_vlan = 12'($urandom_range(0, 4095));
      f.frame_domain = 16'($urandom_range(0, 65535));
      f.frame_ring = 16'($urandom_range(0, 65535));
      return f;
   endfunction

   function automatic rptn_pkg::req_type good_frame(input logic [7:0] code,
                                                    input bit from_secondary);
      rptn_pkg::req_type f;
      f = rand_fields();
      f.action = rptn_pkg::ACT_FRAME;
      f.dest_mac = {rptn_pkg::MAC_PREFIX, code};
      f.tag_present = 1'b1;
      f.source_port_index = (from_secondary ? cfg_model.secondary_port
                                            : cfg_model.primary_port) - 6'd1;
      f.tag_protocol_id = rptn_pkg::TPID_VLAN;
      f.frame_vlan = cfg_model.control_vlan;
      f.frame_domain = cfg_model.ring_domain;
      f.frame_ring = cfg_model.ring_id;
      return f;
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 3))
         0: return cfg_model.hello_code;
         1: return cfg_model.common_flush_code;
         2: return cfg_model.complete_flush_code;
         default: return 8'($urandom_range(rptn_pkg::CODE_LOW, rptn_pkg::CODE_HIGH));
      endcase
   endfunction

   function automatic void push_event(input rptn_pkg::req_type f);
      event_q.push_back(f);
      queued++;
   endfunction

   function automatic void push_link(input logic pl, input logic sl);
      rptn_pkg::req_type f;
      f = rand_fields();
      f.action = rptn_pkg::ACT_LINK;
      f.primary_link = pl;
      f.secondary_link = sl;
      push_event(f);
   endfunction

   function automatic void push_action(input logic [1:0] act);
      rptn_pkg::req_type f;
      f = rand_fields();
      f.action = act;
      push_event(f);
   endfunction

   // a frame that misses the filter in exactly one respect, mostly
   function automatic void push_noise();
      rptn_pkg::req_type f;
      logic [63:0]       rnd;
      f = good_frame(pick_code(), 1'($urandom_range(0, 1)));
      rnd = {$urandom, $urandom};
      case ($urandom_range(0, 8))
         0: f.dest_mac = rnd[47:0];
         1: f.dest_mac[47:8] = f.dest_mac[47:8] ^ (40'd1 << $urandom_range(0, 39));
         2: f.dest_mac[7:0] = ($urandom_range(0, 1) != 0) ? rptn_pkg::CODE_LOW - 8'd1
                                                         : rptn_pkg::CODE_HIGH + 8'd1;
         3: f.tag_present = 1'b0;
         4: f.source_port_index = 6'($urandom_range(0, 63));
         5: f.tag_protocol_id = rptn_pkg::TPID_VLAN ^ 16'($urandom_range(1, 65535));
         6: f.frame_vlan = f.frame_vlan ^ 12'($urandom_range(1, 4095));
         7: f.frame_domain = f.frame_domain ^ 16'($urandom_range(1, 65535));
         default: f.frame_ring = f.frame_ring ^ 16'($urandom_range(1, 65535));
      endcase
      push_event(f);
   endfunction

   task automatic add_random(input int count);
      int target;
      int len;
      target = queued + count;
      while (queued < target) begin
         case ($urandom_range(0, 9))
            0, 1: push_link(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            2, 3: begin
               // drive to preforwarding, then let the timeout run or cut it short
               push_link(1'b0, 1'b1);
               push_link(1'b1, 1'b1);
               len = $urandom_range(0, 34);
               repeat (len) begin
                  if ($urandom_range(0, 7) == 0)
                     push_event(good_frame(cfg_model.hello_code, 1'($urandom_range(0, 1))));
                  else
                     push_action(rptn_pkg::ACT_TICK);
               end
               if ($urandom_range(0, 1) != 0)
                  push_event(good_frame(cfg_model.complete_flush_code,
                                        1'($urandom_range(0, 1))));
            end
            4, 5, 6: push_event(good_frame(pick_code(), 1'($urandom_range(0, 1))));
            7: push_noise();
            8: push_action(rptn_pkg::ACT_TICK);
            default: begin
               if ($urandom_range(0, 3) == 0)
                  push_action(ACT_UNUSED);
               else
                  push_action(rptn_pkg::ACT_TICK);
            end
         endcase
      end
   endtask

   task automatic wait_drain();
      while (event_q.size() != 0 || req_valid || action_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rptn_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rptn_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic write_all(input rptn_pkg::cfg_type c);
      write_reg(rptn_pkg::REG_DOMAIN, c.ring_domain);
      write_reg(rptn_pkg::REG_RING_ID, c.ring_id);
      write_reg(rptn_pkg::REG_PRIMARY_PORT, {10'd0, c.primary_port});
      write_reg(rptn_pkg::REG_SECONDARY_PORT, {10'd0, c.secondary_port});
      write_reg(rptn_pkg::REG_CONTROL_VLAN, {4'd0, c.control_vlan});
      write_reg(rptn_pkg::REG_HELLO_CODE, {8'd0, c.hello_code});
      write_reg(rptn_pkg::REG_COMMON_FLUSH, {8'd0, c.common_flush_code});
      write_reg(rptn_pkg::REG_COMPLETE_FLUSH, {8'd0, c.complete_flush_code});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic rptn_pkg::cfg_type random_cfg();
      rptn_pkg::cfg_type c;
      c.ring_domain = 16'($urandom_range(0, 65535));
      c.ring_id = 16'($urandom_range(0, 65535));
      c.primary_port = 6'($urandom_range(1, 63));
      c.secondary_port = 6'($urandom_range(1, 63));
      c.control_vlan = 12'($urandom_range(0, 4095));
      c.hello_code = 8'($urandom_range(rptn_pkg::CODE_LOW, rptn_pkg::CODE_HIGH));
      c.common_flush_code = 8'($urandom_range(rptn_pkg::CODE_LOW, rptn_pkg::CODE_HIGH));
      c.complete_flush_code = 8'($urandom_range(rptn_pkg::CODE_LOW, rptn_pkg::CODE_HIGH));
      return c;
   endfunction

   initial begin : run
      rptn_pkg::req_type f;
      rptn_pkg::cfg_type ph;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      // directed part, register defaults (ports 1 and 2)
      push_action(rptn_pkg::ACT_TICK);
      push_event(good_frame(cfg_model.hello_code, 1'b0));   // before any link sample
      push_link(1'b1, 1'b1);                                // first sample: up
      push_link(1'b0, 1'b1);                                // primary lost
      push_link(1'b1, 1'b1);                                // preforwarding
      push_action(rptn_pkg::ACT_TICK);
      push_action(rptn_pkg::ACT_TICK);
      push_event(good_frame(cfg_model.hello_code, 1'b1));
      push_event(good_frame(cfg_model.common_flush_code, 1'b0));
      push_event(good_frame(cfg_model.complete_flush_code, 1'b0));
      push_action(rptn_pkg::ACT_TICK);
      push_link(1'b1, 1'b0);
      push_link(1'b1, 1'b1);
      push_link(1'b0, 1'b0);                                // no effect while preforwarding
      push_link(1'b1, 1'b1);
      push_event(good_frame(cfg_model.complete_flush_code, 1'b1));
      push_link(1'b0, 1'b0);                                // both drop at once
      push_link(1'b1, 1'b1);
      push_action(ACT_UNUSED);
      f = good_frame(cfg_model.hello_code, 1'b0);
      f.tag_present = 1'b0;
      push_event(f);
      push_event(good_frame(rptn_pkg::CODE_LOW, 1'b0));     // in range, not a known code
      f = good_frame(rptn_pkg::CODE_HIGH, 1'b1);
      f.source_port_index = 6'd63;
      push_event(f);
      f = good_frame(cfg_model.hello_code, 1'b0);
      f.dest_mac = '1;
      push_event(f);
      f = good_frame(cfg_model.hello_code, 1'b0);
      f.dest_mac = '0;
      push_event(f);
      wait_drain();

      // top extremes
      ph.ring_domain = 16'hFFFF;
      ph.ring_id = 16'hFFFF;
      ph.primary_port = 6'd63;
      ph.secondary_port = 6'd1;
      ph.control_vlan = 12'hFFF;
      ph.hello_code = rptn_pkg::CODE_HIGH;
      ph.common_flush_code = rptn_pkg::CODE_LOW;
      ph.complete_flush_code = 8'h1E;
      write_all(ph);
      add_random(ITEMS_PER_PHASE);
      wait_drain();

      // bottom extremes
      ph.ring_domain = 16'h0000;
      ph.ring_id = 16'h0000;
      ph.primary_port = 6'd1;
      ph.secondary_port = 6'd63;
      ph.control_vlan = 12'h000;
      ph.hello_code = rptn_pkg::CODE_LOW;
      ph.common_flush_code = rptn_pkg::CODE_HIGH;
      ph.complete_flush_code = 8'h12;
      write_all(ph);
      add_random(ITEMS_PER_PHASE);
      wait_drain();

      // both ring ports on the same number
      ph = random_cfg();
      ph.secondary_port = ph.primary_port;
      write_all(ph);
      add_random(ITEMS_PER_PHASE);
      wait_drain();

      // codes outside the protocol range: hello and complete flush never match
      ph = random_cfg();
      ph.hello_code = 8'h00;
      ph.complete_flush_code = 8'hFF;
      write_all(ph);
      add_random(ITEMS_PER_PHASE);
      wait_drain();

      // hello and common flush share a code, hello takes it
      ph = random_cfg();
      ph.common_flush_code = ph.hello_code;
      write_all(ph);
      add_random(ITEMS_PER_PHASE);
      wait_drain();

      // tail without idling on either side
      idle_on = 1'b0;
      write_all(random_cfg());
      add_random(ITEMS_PER_PHASE);
      wait_drain();

      repeat (8) @(posedge clock);
      if (action_q.size() != 0)
         err_count++;
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- ring_protection_transit_node.f -----
rtl/core/rptn_pkg.sv
rtl/core/rptn_cfg.sv
rtl/core/rptn_front.sv
rtl/core/rptn_queue.sv
rtl/core/rptn_back.sv
rtl/core/ring_protection_transit_node.sv
bench/tb.sv
